### src/assert_macros.svh
// assertion macros included by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed: implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

### src/iirpe_pkg.sv
// types, constants and register codes of the order-5 iir position estimator
`default_nettype none

package iirpe_pkg;

  localparam int unsigned DataWidthDefault = 24;
  localparam int unsigned CoefWidth        = 24;
  localparam int unsigned CoefFrac         = 20;
  localparam int unsigned NumCoefs         = 7;
  localparam int unsigned HistDepth        = 5;
  localparam int unsigned CfgIdxWidth      = 3;

  typedef logic signed [CoefWidth-1:0] coef_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t a1;
    coef_t a2;
    coef_t a3;
    coef_t a4;
    coef_t a5;
  } coef_set_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_A1 = 3'd2,
    COEF_A2 = 3'd3,
    COEF_A3 = 3'd4,
    COEF_A4 = 3'd5,
    COEF_A5 = 3'd6
  } coef_idx_e;

  localparam coef_set_t CoefReset = '{
    b0: coef_t'(0),
    b1: coef_t'(20248),
    a1: coef_t'(-3811574),
    a2: coef_t'(5959057),
    a3: coef_t'(-4950327),
    a4: coef_t'(2168455),
    a5: coef_t'(-397620)
  };

endpackage

`default_nettype wire

### src/iirpe_coef_regs.sv
// coefficient register file written through the configuration port
`default_nettype none

module iirpe_coef_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [iirpe_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [iirpe_pkg::CoefWidth-1:0]     cfg_data_i,
  output iirpe_pkg::coef_set_t                coefs_o
);

  iirpe_pkg::coef_set_t coefs_q, coefs_d;

  always_comb begin
    coefs_d = coefs_q;
    if (cfg_we_i) begin
      unique case (iirpe_pkg::coef_idx_e'(cfg_index_i))
        iirpe_pkg::COEF_B0: coefs_d.b0 = cfg_data_i;
        iirpe_pkg::COEF_B1: coefs_d.b1 = cfg_data_i;
        iirpe_pkg::COEF_A1: coefs_d.a1 = cfg_data_i;
        iirpe_pkg::COEF_A2: coefs_d.a2 = cfg_data_i;
        iirpe_pkg::COEF_A3: coefs_d.a3 = cfg_data_i;
        iirpe_pkg::COEF_A4: coefs_d.a4 = cfg_data_i;
        iirpe_pkg::COEF_A5: coefs_d.a5 = cfg_data_i;
        default:            coefs_d    = coefs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= iirpe_pkg::CoefReset;
    end else begin
      coefs_q <= coefs_d;
    end
  end

  assign coefs_o = coefs_q;

endmodule

`default_nettype wire

### src/iirpe_datapath.sv
// multiply, sum, round and saturate for one filter output
`default_nettype none

module iirpe_datapath #(
  parameter int unsigned DataWidth = iirpe_pkg::DataWidthDefault
) (
  input  logic signed [DataWidth-1:0]                         sample_i,
  input  logic signed [DataWidth-1:0]                         u_prev_i,
  input  logic [iirpe_pkg::HistDepth-1:0][DataWidth-1:0]      y_hist_i,
  input  iirpe_pkg::coef_set_t                                coefs_i,
  output logic signed [DataWidth-1:0]                         estimate_o,
  output logic                                                saturated_o
);

  localparam int unsigned ProdW = DataWidth + iirpe_pkg::CoefWidth;
  localparam int unsigned AccW  = ProdW + 3;
  localparam int unsigned ShW   = AccW - iirpe_pkg::CoefFrac;

  localparam logic signed [ShW-1:0] MaxV =
    {{(ShW - DataWidth + 1){1'b0}}, {(DataWidth - 1){1'b1}}};
  localparam logic signed [ShW-1:0] MinV = ~MaxV;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (iirpe_pkg::CoefFrac - 1);

  logic signed [ProdW-1:0] p_b0, p_b1, p_a1, p_a2, p_a3, p_a4, p_a5;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  acc_rnd;
  logic signed [ShW-1:0]   y_full;

  assign p_b0 = sample_i * coefs_i.b0;
  assign p_b1 = u_prev_i * coefs_i.b1;
  assign p_a1 = $signed(y_hist_i[0]) * coefs_i.a1;
  assign p_a2 = $signed(y_hist_i[1]) * coefs_i.a2;
  assign p_a3 = $signed(y_hist_i[2]) * coefs_i.a3;
  assign p_a4 = $signed(y_hist_i[3]) * coefs_i.a4;
  assign p_a5 = $signed(y_hist_i[4]) * coefs_i.a5;

  // balanced adder tree, feedback terms subtracted
  assign acc = ((AccW'(p_b0) + AccW'(p_b1)) - (AccW'(p_a1) + AccW'(p_a2)))
             - ((AccW'(p_a3) + AccW'(p_a4)) + AccW'(p_a5));

  assign acc_rnd = acc + RoundHalf;
  assign y_full  = ShW'(acc_rnd >>> iirpe_pkg::CoefFrac);

  always_comb begin
    priority if (y_full > MaxV) begin
      estimate_o  = MaxV[DataWidth-1:0];
      saturated_o = 1'b1;
    end else if (y_full < MinV) begin
      estimate_o  = MinV[DataWidth-1:0];
      saturated_o = 1'b1;
    end else begin
      estimate_o  = y_full[DataWidth-1:0];
      saturated_o = 1'b0;
    end
  end

endmodule

`default_nettype wire

### src/iir_order5_position_estimator.sv
// top level of the order-5 direct-form-i iir position estimator
`default_nettype none

// One sample in, one estimate out: y = b0*u + b1*u_prev - a1*y1 - ... - a5*y5, with
// Q8.16 samples, Q4.20 coefficients, exact products, one round-half-up to Q8.16 and
// saturation (saturated_o marks a clipped result). The block accepts one transaction
// every cycle unless the result side stalls. A sample waits in the input register; when
// it advances, seven parallel multiplies and one adder tree fill the result register and
// update the feedback history, and the estimate is shown from the result register. That
// single pass through the loop is what sets the one-per-cycle rate. Back-pressure on the
// result side holds the input register while the result waits. Coefficients come from
// reset values and are rewritten by index through the configuration port only while no
// transaction is in flight; the user must keep to this, the block does not enforce it.
module iir_order5_position_estimator #(
  parameter int unsigned DataWidth = iirpe_pkg::DataWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [iirpe_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [iirpe_pkg::CoefWidth-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [DataWidth-1:0]         sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [DataWidth-1:0]         estimate_o,
  output logic                                saturated_o
);

  iirpe_pkg::coef_set_t coefs;

  logic                                             in_vld_q, in_vld_d;
  logic signed [DataWidth-1:0]                      in_sample_q;
  logic                                             res_vld_q, res_vld_d;
  logic signed [DataWidth-1:0]                      est_q;
  logic                                             sat_q;
  logic signed [DataWidth-1:0]                      u_prev_q;
  logic [iirpe_pkg::HistDepth-1:0][DataWidth-1:0]   y_hist_q;

  logic signed [DataWidth-1:0] est_calc;
  logic                        sat_calc;
  logic                        advance;
  logic                        in_fire;

  iirpe_coef_regs u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coefs_o     (coefs)
  );

  iirpe_datapath #(
    .DataWidth (DataWidth)
  ) u_datapath (
    .sample_i    (in_sample_q),
    .u_prev_i    (u_prev_q),
    .y_hist_i    (y_hist_q),
    .coefs_i     (coefs),
    .estimate_o  (est_calc),
    .saturated_o (sat_calc)
  );

  assign advance    = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (advance) begin
      res_vld_d = 1'b1;
    end else if (out_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      u_prev_q  <= '0;
      y_hist_q  <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
      if (advance) begin
        u_prev_q <= in_sample_q;
        y_hist_q <= {y_hist_q[iirpe_pkg::HistDepth-2:0], est_calc};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_sample_q <= sample_i;
    end
    if (advance) begin
      est_q <= est_calc;
      sat_q <= sat_calc;
    end
  end

  assign out_valid_o = res_vld_q;
  assign estimate_o  = est_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

### src/iirpe_checker.sv
// port-level checker for the order-5 iir position estimator, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module iirpe_checker #(
  parameter int unsigned DataWidth = iirpe_pkg::DataWidthDefault
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [DataWidth-1:0] estimate_o,
  input logic                        saturated_o
);

  localparam logic [DataWidth-1:0] MaxEst = {1'b0, {(DataWidth - 1){1'b1}}};
  localparam logic [DataWidth-1:0] MinEst = {1'b1, {(DataWidth - 1){1'b0}}};

  // stalled result holds
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(estimate_o) && $stable(saturated_o))

  // a clipped result sits at one of the range limits
  `ASSERT_IMP(a_sat_limit, clk_i, rst_ni, out_valid_o && saturated_o, estimate_o == MaxEst || estimate_o == MinEst)

  // with the result side empty the input side never stalls
  `ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // an accepted transaction is followed by a valid result on the result side
  `ASSERT_IMP(a_latency, clk_i, rst_ni, in_valid_i && in_ready_o, ##2 out_valid_o)

endmodule

bind iir_order5_position_estimator iirpe_checker #(
  .DataWidth (DataWidth)
) u_iirpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .estimate_o  (estimate_o),
  .saturated_o (saturated_o)
);

`default_nettype wire

### sim/tb_top.sv
// self-checking testbench of the order-5 iir position estimator with a built-in filter predictor
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW = iirpe_pkg::DataWidthDefault;
  localparam int unsigned IdxW  = iirpe_pkg::CfgIdxWidth;
  localparam logic [IdxW-1:0] IdxSpare = IdxW'(iirpe_pkg::NumCoefs);

  typedef logic signed [DataW-1:0] sample_t;

  typedef struct {
    sample_t estimate;
    logic    saturated;
  } result_t;

  localparam sample_t MaxSample = sample_t'(2 ** (DataW - 1) - 1);
  localparam sample_t MinSample = sample_t'(-(2 ** (DataW - 1)));
  localparam iirpe_pkg::coef_t MaxCoef =
    iirpe_pkg::coef_t'(2 ** (iirpe_pkg::CoefWidth - 1) - 1);
  localparam iirpe_pkg::coef_t MinCoef =
    iirpe_pkg::coef_t'(-(2 ** (iirpe_pkg::CoefWidth - 1)));
  localparam iirpe_pkg::coef_t UnitCoef = iirpe_pkg::coef_t'(2 ** iirpe_pkg::CoefFrac);
  localparam iirpe_pkg::coef_t HalfCoef = iirpe_pkg::coef_t'(2 ** (iirpe_pkg::CoefFrac - 1));

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [IdxW-1:0]  cfg_index_i = '0;
  iirpe_pkg::coef_t cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  sample_t          sample_i    = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  sample_t          estimate_o;
  logic             saturated_o;

  iir_order5_position_estimator #(
    .DataWidth(DataW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .estimate_o (estimate_o),
    .saturated_o(saturated_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // filter state mirrored by the predictor
  iirpe_pkg::coef_t taps [iirpe_pkg::NumCoefs];
  sample_t          prev_sample;
  sample_t          past_est [iirpe_pkg::HistDepth];

  sample_t samples_q [$];
  sample_t opening_q [$];
  result_t estimates_q [$];

  int      failures  = 0;
  int      send_gap  = 0;
  int      send_calm = 0;
  int      hold_gap  = 0;
  int      hold_calm = 0;
  result_t want;

  function automatic result_t filter_step(sample_t u);
    longint  acc;
    longint  y;
    result_t r;
    acc = longint'(taps[iirpe_pkg::COEF_B0]) * longint'(u)
        + longint'(taps[iirpe_pkg::COEF_B1]) * longint'(prev_sample);
    for (int i = 0; i < iirpe_pkg::HistDepth; i++) begin
      acc -= longint'(taps[int'(iirpe_pkg::COEF_A1) + i]) * longint'(past_est[i]);
    end
    y = (acc + (64'sd1 <<< (iirpe_pkg::CoefFrac - 1))) >>> iirpe_pkg::CoefFrac;
    r.saturated = 1'b0;
    if (y > longint'(MaxSample)) begin
      y = longint'(MaxSample);
      r.saturated = 1'b1;
    end else if (y < longint'(MinSample)) begin
      y = longint'(MinSample);
      r.saturated = 1'b1;
    end
    r.estimate = sample_t'(y);
    for (int i = iirpe_pkg::HistDepth - 1; i > 0; i--) begin
      past_est[i] = past_est[i - 1];
    end
    past_est[0] = r.estimate;
    prev_sample = u;
    return r;
  endfunction

  // mostly no idling, short gaps often, long gaps rarely, and calm stretches
  function automatic int idle_len(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? MaxSample : MinSample;
      1, 2, 3: return sample_t'(int'($urandom_range(0, 4095)) - 2048);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // input side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        estimates_q.push_back(filter_step(sample_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (samples_q.size() > 0) begin
          in_valid_i <= 1'b1;
          sample_i   <= samples_q.pop_front();
          send_gap   = idle_len(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (estimates_q.size() == 0) begin
          $display("%0t: estimate %0d with no transaction outstanding", $time, estimate_o);
          failures++;
        end else begin
          want = estimates_q.pop_front();
          if (estimate_o !== want.estimate) begin
            $display("%0t: estimate mismatch, expected %0d, got %0d",
                     $time, want.estimate, estimate_o);
            failures++;
          end
          if (saturated_o !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b, got %0b",
                     $time, want.saturated, saturated_o);
            failures++;
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        hold_gap = idle_len(hold_calm);
      end
    end
  end

  task automatic settle();
    while (samples_q.size() > 0 || in_valid_i || estimates_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // program all taps while idle, optionally poking the unused index too
  task automatic run_phase(input iirpe_pkg::coef_t t [iirpe_pkg::NumCoefs],
                           input int n_random, input bit spare);
    settle();
    for (int i = 0; i < iirpe_pkg::NumCoefs; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= IdxW'(i);
      cfg_data_i  <= t[i];
      taps[i] = t[i];
    end
    if (spare) begin
      @(posedge clk_i);
      cfg_index_i <= IdxSpare;
      cfg_data_i  <= iirpe_pkg::coef_t'($urandom);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    foreach (opening_q[i]) samples_q.push_back(opening_q[i]);
    opening_q.delete();
    repeat (n_random) samples_q.push_back(rand_sample());
  endtask

  initial begin
    iirpe_pkg::coef_t t [iirpe_pkg::NumCoefs];
    iirpe_pkg::coef_t dflt [iirpe_pkg::NumCoefs];
    dflt = '{iirpe_pkg::CoefReset.b0, iirpe_pkg::CoefReset.b1, iirpe_pkg::CoefReset.a1,
             iirpe_pkg::CoefReset.a2, iirpe_pkg::CoefReset.a3, iirpe_pkg::CoefReset.a4,
             iirpe_pkg::CoefReset.a5};
    taps = dflt;
    prev_sample = '0;
    foreach (past_est[i]) past_est[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients, no register writes
    samples_q = '{sample_t'(0), MaxSample, MaxSample, MinSample, MinSample, sample_t'(1),
                  sample_t'(-1), sample_t'(0), sample_t'(24'h555555), sample_t'(24'haaaaaa)};
    repeat (250) samples_q.push_back(rand_sample());

    // pass-through, plus a write to the unused index that must change nothing
    t = '{UnitCoef, iirpe_pkg::coef_t'(0), iirpe_pkg::coef_t'(0), iirpe_pkg::coef_t'(0),
          iirpe_pkg::coef_t'(0), iirpe_pkg::coef_t'(0), iirpe_pkg::coef_t'(0)};
    opening_q = '{sample_t'(0), sample_t'(1), sample_t'(-1), MaxSample, MinSample};
    run_phase(t, 100, 1'b1);

    // half gain exposes round half up
    t[iirpe_pkg::COEF_B0] = HalfCoef;
    opening_q = '{sample_t'(1), sample_t'(-1), sample_t'(3), sample_t'(-3)};
    run_phase(t, 100, 1'b0);

    // largest gains overflow in both directions
    t[iirpe_pkg::COEF_B0] = MaxCoef;
    opening_q = '{MaxSample, MinSample, sample_t'(1), sample_t'(-1)};
    run_phase(t, 100, 1'b0);
    t[iirpe_pkg::COEF_B0] = MinCoef;
    opening_q = '{MinSample, MaxSample, sample_t'(1), sample_t'(-1)};
    run_phase(t, 100, 1'b0);

    foreach (t[i]) t[i] = MaxCoef;
    run_phase(t, 150, 1'b0);
    foreach (t[i]) t[i] = MinCoef;
    run_phase(t, 150, 1'b0);

    repeat (2) begin
      foreach (t[i]) t[i] = iirpe_pkg::coef_t'($urandom);
      run_phase(t, 100, 1'b1);
    end

    // small feedback keeps the loop stable
    repeat (3) begin
      t[iirpe_pkg::COEF_B0] = iirpe_pkg::coef_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      t[iirpe_pkg::COEF_B1] = iirpe_pkg::coef_t'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
      for (int i = int'(iirpe_pkg::COEF_A1); i < iirpe_pkg::NumCoefs; i++) begin
        t[i] = iirpe_pkg::coef_t'(int'($urandom_range(0, 2 ** 18)) - 2 ** 17);
      end
      run_phase(t, 150, 1'b0);
    end

    run_phase(dflt, 100, 1'b1);

    settle();
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
